// ===== design/tmcp_pkg.sv =====
// tmcp_pkg: types and constants for the tagged mesh chunk parser
// no dependencies
`default_nettype none
package tmcp_pkg;

  typedef enum logic [2:0] {
    KIND_VERTEX = 3'd0,
    KIND_FACE   = 3'd1,
    KIND_UV     = 3'd2,
    KIND_COLOR  = 3'd3,
    KIND_MASK   = 3'd4,
    KIND_GROUP  = 3'd5,
    KIND_END    = 3'd6,
    KIND_TRUNC  = 3'd7
  } kind_e;

  localparam logic [31:0] HeaderBytes = 32'd36;
  localparam logic [31:0] NameBias    = 32'd16;
  localparam logic [31:0] NamePad     = 32'd8;
  localparam logic [31:0] LenBias     = 32'd8;
  localparam logic [31:0] TriMark     = 32'hffff_ffff;
  localparam logic [31:0] SignBit     = 32'h8000_0000;

  localparam logic [31:0] TagEnd    = 32'h0000_0000;
  localparam logic [31:0] TagVertex = 32'h0000_2711;
  localparam logic [31:0] TagFace   = 32'h0000_4e21;
  localparam logic [31:0] TagUv     = 32'h0000_61a9;
  localparam logic [31:0] TagColor  = 32'h0000_88b9;
  localparam logic [31:0] TagMask   = 32'h0000_7532;
  localparam logic [31:0] TagGroup  = 32'h0000_9c41;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] elem_index;
    logic [1:0]  corner;
    logic [2:0]  n_corners;
    logic [31:0] val_a;
    logic [31:0] val_b;
    logic [31:0] val_c;
    logic [31:0] val_d;
  } result_t;

endpackage
`default_nettype wire

// ===== design/tmcp_in_if.sv =====
// tmcp_in_if: byte channel into the parser
// no dependencies
`default_nettype none
interface tmcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface
`default_nettype wire

// ===== design/tmcp_out_if.sv =====
// tmcp_out_if: result channel out of the parser
// no dependencies
`default_nettype none
interface tmcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] elem_index;
  logic [1:0]  corner;
  logic [2:0]  n_corners;
  logic [31:0] val_a;
  logic [31:0] val_b;
  logic [31:0] val_c;
  logic [31:0] val_d;

  modport source (output valid, output kind, output elem_index, output corner,
                  output n_corners, output val_a, output val_b, output val_c,
                  output val_d, input ready);
  modport sink (input valid, input kind, input elem_index, input corner,
                input n_corners, input val_a, input val_b, input val_c,
                input val_d, output ready);
endinterface
`default_nettype wire

// ===== design/tmcp_quad_store.sv =====
// tmcp_quad_store: one bit per face, set when the face is a quad
// single write port, registered read port; no dependencies
`default_nettype none
module tmcp_quad_store #(
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic                     wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic                          rd_data_o
);

  logic mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule
`default_nettype wire

// ===== design/tagged_mesh_chunk_parser.sv =====
// tagged_mesh_chunk_parser: byte-serial parser for a tagged mesh file
// uses tmcp_pkg, tmcp_in_if, tmcp_out_if, tmcp_quad_store
//
// usage
//   in_i carries one file byte per item with stream_end on the last byte.
//   out_o carries at most one result per input byte: vertex, face, uv corner,
//   color, mask word, group word, end tag, or a truncation flag when the
//   stream ends before the end tag.
//   every input byte is decoded in the cycle it is accepted; its result sits
//   in the output register from the next cycle on.
//   throughput is one byte per cycle; the input stalls only while a result
//   is held in the output register and out_o.ready is low.
//   the face shape store is a one-bit memory with a registered read port,
//   addressed by the element counter; a uv chunk reads it at least seven
//   bytes after the counter moves, so the read never stalls the input.
//   reset puts the parser at the start of the header with no result pending.
//   the face shape store is not cleared; uv elements only look up faces of
//   the current file that were written.
`default_nettype none
module tagged_mesh_chunk_parser #(
  parameter int unsigned MAX_FACES = 65536
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tmcp_in_if.sink   in_i,
  tmcp_out_if.source out_o
);
  import tmcp_pkg::*;

  localparam int unsigned AW = $clog2(MAX_FACES);
  localparam int unsigned FW = $clog2(MAX_FACES + 1);
  localparam logic [31:0] MaxFaces = 32'(MAX_FACES);

  typedef enum logic [3:0] {
    PH_HDR, PH_NAMELEN, PH_SKIP, PH_TAG, PH_LENSKIP, PH_PRE, PH_COUNT,
    PH_VERT, PH_FACE, PH_UV, PH_COLOR, PH_MASK, PH_GROUP, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  byte_pos_q, byte_pos_d;
  logic [31:0] skip_left_q, skip_left_d;
  logic [63:0] word_accum_q, word_accum_d;
  logic [63:0] elems_left_q, elems_left_d;
  logic [31:0] elem_counter_q, elem_counter_d;
  logic [2:0]  sub_pos_q, sub_pos_d;
  logic [31:0] hold_q [3];
  logic [31:0] hold_d [3];
  logic [FW-1:0] faces_written_q, faces_written_d;
  logic        out_valid_q;
  result_t     res_q, res_d;
  logic        emit;
  logic        accept;
  logic        quad_rd;
  logic        quad_we;
  logic        quad_wd;

  logic [63:0] acc;
  logic [31:0] w;
  logic [31:0] len;
  logic [31:0] nc;
  logic [2:0]  k;
  logic        elem_done;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    phase_d         = phase_q;
    byte_pos_d      = byte_pos_q;
    skip_left_d     = skip_left_q;
    elems_left_d    = elems_left_q;
    elem_counter_d  = elem_counter_q;
    sub_pos_d       = sub_pos_q;
    hold_d          = hold_q;
    faces_written_d = faces_written_q;
    res_d           = '0;
    emit            = 1'b0;
    elem_done       = 1'b0;
    quad_we         = 1'b0;
    quad_wd         = 1'b0;
    len             = '0;
    nc              = 32'd4;
    k               = 3'd0;

    acc = word_accum_q;
    if (phase_q == PH_COUNT) begin
      acc = acc | ({56'd0, in_i.data_byte} << {byte_pos_q[2:0], 3'b000});
    end else if (phase_q inside {PH_NAMELEN, PH_TAG, PH_LENSKIP, PH_VERT, PH_FACE,
                                 PH_UV, PH_COLOR, PH_MASK, PH_GROUP}) begin
      acc = acc | ({56'd0, in_i.data_byte} << {byte_pos_q[1:0], 3'b000});
    end
    w = acc[31:0];
    word_accum_d = acc;

    case (phase_q)
      PH_HDR: begin
        if (skip_left_q <= 32'd1) begin
          skip_left_d  = '0;
          phase_d      = PH_NAMELEN;
          byte_pos_d   = '0;
          word_accum_d = '0;
        end else begin
          skip_left_d = skip_left_q - 32'd1;
        end
      end
      PH_NAMELEN: begin
        if (byte_pos_q == 4'd3) begin
          len          = (w < NameBias) ? 32'd0 : w - NameBias;
          len          = len + NamePad;
          byte_pos_d   = '0;
          word_accum_d = '0;
          if (len == 32'd0) begin
            phase_d = PH_TAG;
          end else begin
            skip_left_d = len;
            phase_d     = PH_SKIP;
          end
        end else begin
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_SKIP: begin
        if (skip_left_q <= 32'd1) begin
          skip_left_d  = '0;
          phase_d      = PH_TAG;
          byte_pos_d   = '0;
          word_accum_d = '0;
        end else begin
          skip_left_d = skip_left_q - 32'd1;
        end
      end
      PH_TAG: begin
        if (byte_pos_q == 4'd3) begin
          byte_pos_d   = '0;
          word_accum_d = '0;
          if (w == TagEnd) begin
            emit       = 1'b1;
            res_d.kind = KIND_END;
            phase_d    = PH_DONE;
          end else begin
            phase_d = PH_PRE;
            case (w)
              TagVertex: k = 3'd0;
              TagFace:   k = 3'd1;
              TagUv:     k = 3'd2;
              TagColor:  k = 3'd3;
              TagMask:   k = 3'd4;
              TagGroup:  k = 3'd5;
              default:   phase_d = PH_LENSKIP;
            endcase
            if (phase_d == PH_PRE) begin
              sub_pos_d = k;
            end
          end
        end else begin
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_LENSKIP: begin
        if (byte_pos_q == 4'd3) begin
          byte_pos_d   = '0;
          word_accum_d = '0;
          len          = w - LenBias;
          if (len == 32'd0) begin
            phase_d = PH_TAG;
          end else begin
            skip_left_d = len;
            phase_d     = PH_SKIP;
          end
        end else begin
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_PRE: begin
        if (byte_pos_q == 4'd3) begin
          phase_d      = PH_COUNT;
          byte_pos_d   = '0;
          word_accum_d = '0;
        end else begin
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_COUNT: begin
        if (byte_pos_q == 4'd7) begin
          elems_left_d   = acc;
          elem_counter_d = '0;
          byte_pos_d     = '0;
          sub_pos_d      = '0;
          word_accum_d   = '0;
          k = (sub_pos_q < 3'd6) ? sub_pos_q : 3'd0;
          if (k == 3'd1) begin
            faces_written_d = '0;
          end
          if (acc == 64'd0) begin
            phase_d = PH_TAG;
          end else begin
            case (k)
              3'd0:    phase_d = PH_VERT;
              3'd1:    phase_d = PH_FACE;
              3'd2:    phase_d = PH_UV;
              3'd3:    phase_d = PH_COLOR;
              3'd4:    phase_d = PH_MASK;
              default: phase_d = PH_GROUP;
            endcase
          end
        end else begin
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_VERT: begin
        if (byte_pos_q == 4'd11) begin
          emit             = 1'b1;
          res_d.kind       = KIND_VERTEX;
          res_d.elem_index = elem_counter_q;
          res_d.val_a      = hold_q[0];
          res_d.val_b      = hold_q[1] ^ SignBit;
          res_d.val_c      = w ^ SignBit;
          elem_done        = 1'b1;
        end else begin
          if (byte_pos_q[1:0] == 2'd3) begin
            hold_d[{1'b0, byte_pos_q[2]}] = w;
            word_accum_d = '0;
          end
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_FACE: begin
        if (byte_pos_q == 4'd15) begin
          emit             = 1'b1;
          res_d.kind       = KIND_FACE;
          res_d.elem_index = elem_counter_q;
          res_d.n_corners  = 3'd4;
          if (w == TriMark) begin
            nc              = 32'd3;
            res_d.n_corners = 3'd3;
            res_d.val_a     = hold_q[0];
            res_d.val_b     = hold_q[1];
            res_d.val_c     = hold_q[2];
          end else if (w == 32'd0) begin
            res_d.val_b = hold_q[0];
            res_d.val_c = hold_q[1];
            res_d.val_d = hold_q[2];
          end else begin
            res_d.val_a = hold_q[0];
            res_d.val_b = hold_q[1];
            res_d.val_c = hold_q[2];
            res_d.val_d = w;
          end
          if (elem_counter_q < MaxFaces) begin
            quad_we         = 1'b1;
            quad_wd         = (nc == 32'd4);
            faces_written_d = FW'(elem_counter_q + 32'd1);
          end
          elem_done = 1'b1;
        end else begin
          if (byte_pos_q[1:0] == 2'd3) begin
            if (byte_pos_q[3:2] != 2'd3) begin
              hold_d[byte_pos_q[3:2]] = w;
            end
            word_accum_d = '0;
          end
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_UV: begin
        if (byte_pos_q == 4'd7) begin
          if (elem_counter_q < 32'(faces_written_q) && elem_counter_q < MaxFaces) begin
            nc = quad_rd ? 32'd4 : 32'd3;
          end
          if (32'(sub_pos_q) < nc) begin
            emit             = 1'b1;
            res_d.kind       = KIND_UV;
            res_d.elem_index = elem_counter_q;
            res_d.corner     = sub_pos_q[1:0];
            res_d.n_corners  = nc[2:0];
            res_d.val_a      = hold_q[0];
            res_d.val_b      = w;
          end
          byte_pos_d   = '0;
          word_accum_d = '0;
          sub_pos_d    = sub_pos_q + 3'd1;
          if (sub_pos_q == 3'd3) begin
            elem_done = 1'b1;
          end
        end else begin
          if (byte_pos_q == 4'd3) begin
            hold_d[0]    = w;
            word_accum_d = '0;
          end
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_COLOR: begin
        if (byte_pos_q == 4'd3) begin
          emit             = 1'b1;
          res_d.kind       = KIND_COLOR;
          res_d.elem_index = elem_counter_q;
          res_d.val_a      = {24'd0, w[23:16]};
          res_d.val_b      = {24'd0, w[15:8]};
          res_d.val_c      = {24'd0, w[7:0]};
          res_d.val_d      = {24'd0, w[31:24]};
          elem_done        = 1'b1;
        end else begin
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      PH_MASK, PH_GROUP: begin
        if (byte_pos_q == 4'd1) begin
          emit             = 1'b1;
          res_d.kind       = (phase_q == PH_MASK) ? KIND_MASK : KIND_GROUP;
          res_d.elem_index = elem_counter_q;
          res_d.val_a      = {16'd0, w[15:0]};
          elem_done        = 1'b1;
        end else begin
          byte_pos_d = byte_pos_q + 4'd1;
        end
      end
      default: begin
      end
    endcase

    if (elem_done) begin
      if (elem_counter_q != 32'hffff_ffff) begin
        elem_counter_d = elem_counter_q + 32'd1;
      end
      elems_left_d = elems_left_q - 64'd1;
      byte_pos_d   = '0;
      sub_pos_d    = '0;
      word_accum_d = '0;
      if (elems_left_q == 64'd1) begin
        phase_d = PH_TAG;
      end
    end

    if (in_i.stream_end) begin
      if (phase_d != PH_DONE) begin
        emit       = 1'b1;
        res_d      = '0;
        res_d.kind = KIND_TRUNC;
      end
      phase_d         = PH_HDR;
      byte_pos_d      = '0;
      skip_left_d     = HeaderBytes;
      word_accum_d    = '0;
      elems_left_d    = '0;
      elem_counter_d  = '0;
      sub_pos_d       = '0;
      hold_d          = '{default: '0};
      faces_written_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HDR;
      byte_pos_q      <= '0;
      skip_left_q     <= HeaderBytes;
      word_accum_q    <= '0;
      elems_left_q    <= '0;
      elem_counter_q  <= '0;
      sub_pos_q       <= '0;
      hold_q          <= '{default: '0};
      faces_written_q <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (accept) begin
        phase_q         <= phase_d;
        byte_pos_q      <= byte_pos_d;
        skip_left_q     <= skip_left_d;
        word_accum_q    <= word_accum_d;
        elems_left_q    <= elems_left_d;
        elem_counter_q  <= elem_counter_d;
        sub_pos_q       <= sub_pos_d;
        hold_q          <= hold_d;
        faces_written_q <= faces_written_d;
        out_valid_q     <= emit;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_q <= res_d;
    end
  end

  tmcp_quad_store #(
    .DEPTH (MAX_FACES)
  ) u_quad_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept && quad_we),
    .wr_addr_i (elem_counter_q[AW-1:0]),
    .wr_data_i (quad_wd),
    .rd_addr_i (elem_counter_q[AW-1:0]),
    .rd_data_o (quad_rd)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = res_q.kind;
  assign out_o.elem_index = res_q.elem_index;
  assign out_o.corner     = res_q.corner;
  assign out_o.n_corners  = res_q.n_corners;
  assign out_o.val_a      = res_q.val_a;
  assign out_o.val_b      = res_q.val_b;
  assign out_o.val_c      = res_q.val_c;
  assign out_o.val_d      = res_q.val_d;

  a_face_corners: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.kind == KIND_FACE || res_q.kind == KIND_UV)
      |-> (res_q.n_corners == 3'd3 || res_q.n_corners == 3'd4))
    else $error("face or uv result with bad corner count");

  a_uv_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_UV |-> sub_pos_q < 3'd4)
    else $error("uv corner position out of range");

  a_faces_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(faces_written_q) <= MaxFaces)
    else $error("face count beyond store depth");

  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.stream_end |=> phase_q == PH_HDR && faces_written_q == '0)
    else $error("parser did not restart after last byte");

endmodule
`default_nettype wire

// ===== verif/tmcp_result_checker.sv =====
// tmcp_result_checker: predicts parser results from accepted input bytes and
// compares them with accepted output items; depends on tmcp_pkg and the channel interfaces
`timescale 1ns / 1ps
module tmcp_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tmcp_in_if   in_i,
  tmcp_out_if  out_i,
  output int   errors_o,
  output int   pending_o
);
  import tmcp_pkg::*;

  localparam logic [3:0] PhHdr = 4'd0, PhNameLen = 4'd1, PhSkip = 4'd2, PhTag = 4'd3,
    PhLenSkip = 4'd4, PhPre = 4'd5, PhCount = 4'd6, PhVert = 4'd7, PhFace = 4'd8,
    PhUv = 4'd9, PhColor = 4'd10, PhMask = 4'd11, PhGroup = 4'd12, PhDone = 4'd13;
  localparam int unsigned FaceSlots = 65536;

  logic [3:0]  phase;
  logic [3:0]  bpos;
  logic [31:0] skip_left;
  logic [63:0] accum;
  logic [63:0] elems_left;
  logic [31:0] elem_cnt;
  logic [2:0]  sub_pos;
  logic [31:0] hold [3];
  logic [31:0] faces_seen;
  bit          quad_of_face [FaceSlots];
  result_t     expected_results [$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = expected_results.size();

  function automatic result_t mk(kind_e k, logic [31:0] idx, logic [1:0] cn, logic [2:0] nc,
                                 logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [31:0] d);
    result_t r;
    r.kind = k; r.elem_index = idx; r.corner = cn; r.n_corners = nc;
    r.val_a = a; r.val_b = b; r.val_c = c; r.val_d = d;
    return r;
  endfunction

  task automatic restart_file();
    phase = PhHdr; bpos = 0; skip_left = HeaderBytes; accum = 0; elems_left = 0;
    elem_cnt = 0; sub_pos = 0; hold[0] = 0; hold[1] = 0; hold[2] = 0; faces_seen = 0;
  endtask

  task automatic goto_tag();
    phase = PhTag; bpos = 0; accum = 0;
  endtask

  task automatic start_skip(logic [31:0] n);
    if (n == 0) goto_tag();
    else begin
      skip_left = n;
      phase = PhSkip;
    end
  endtask

  task automatic next_element();
    if (elem_cnt != 32'hffff_ffff) elem_cnt++;
    elems_left--;
    bpos = 0; sub_pos = 0; accum = 0;
    if (elems_left == 0) goto_tag();
  endtask

  task automatic parse_byte(logic [7:0] b, logic last);
    logic [31:0] w, nc, ln;
    logic        got;
    result_t     r;
    got = 0;
    r = '0;
    if (phase >= PhNameLen && phase <= PhGroup && phase != PhSkip && phase != PhPre) begin
      if (phase == PhCount) accum |= 64'(b) << (8 * bpos[2:0]);
      else accum |= 64'(b) << (8 * bpos[1:0]);
    end
    w = accum[31:0];
    case (phase)
      PhHdr: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) begin
          phase = PhNameLen; bpos = 0; accum = 0;
        end
      end
      PhNameLen: begin
        if (bpos == 3) begin
          ln = (w < NameBias) ? 32'd0 : w - NameBias;
          bpos = 0; accum = 0;
          start_skip(NamePad + ln);
        end else bpos++;
      end
      PhSkip: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) goto_tag();
      end
      PhTag: begin
        if (bpos == 3) begin
          bpos = 0; accum = 0;
          if (w == TagEnd) begin
            r = mk(KIND_END, 0, 0, 0, 0, 0, 0, 0);
            got = 1;
            phase = PhDone;
          end else if (w == TagVertex) begin sub_pos = 0; phase = PhPre; end
          else if (w == TagFace) begin sub_pos = 1; phase = PhPre; end
          else if (w == TagUv) begin sub_pos = 2; phase = PhPre; end
          else if (w == TagColor) begin sub_pos = 3; phase = PhPre; end
          else if (w == TagMask) begin sub_pos = 4; phase = PhPre; end
          else if (w == TagGroup) begin sub_pos = 5; phase = PhPre; end
          else phase = PhLenSkip;
        end else bpos++;
      end
      PhLenSkip: begin
        if (bpos == 3) begin
          bpos = 0; accum = 0;
          start_skip(w - LenBias);
        end else bpos++;
      end
      PhPre: begin
        if (bpos == 3) begin
          phase = PhCount; bpos = 0; accum = 0;
        end else bpos++;
      end
      PhCount: begin
        if (bpos == 7) begin
          elems_left = accum;
          elem_cnt = 0;
          if (sub_pos == 1) faces_seen = 0;
          case (sub_pos)
            0: phase = PhVert;
            1: phase = PhFace;
            2: phase = PhUv;
            3: phase = PhColor;
            4: phase = PhMask;
            default: phase = PhGroup;
          endcase
          bpos = 0; sub_pos = 0; accum = 0;
          if (elems_left == 0) goto_tag();
        end else bpos++;
      end
      PhVert: begin
        if (bpos == 11) begin
          r = mk(KIND_VERTEX, elem_cnt, 0, 0, hold[0], hold[1] ^ SignBit, w ^ SignBit, 0);
          got = 1;
          next_element();
        end else begin
          if (bpos[1:0] == 2'd3) begin
            hold[bpos[2]] = w;
            accum = 0;
          end
          bpos++;
        end
      end
      PhFace: begin
        if (bpos == 15) begin
          nc = 4;
          if (w == TriMark) begin
            nc = 3;
            r = mk(KIND_FACE, elem_cnt, 0, 3, hold[0], hold[1], hold[2], 0);
          end else if (w == 0) begin
            r = mk(KIND_FACE, elem_cnt, 0, 4, 0, hold[0], hold[1], hold[2]);
          end else begin
            r = mk(KIND_FACE, elem_cnt, 0, 4, hold[0], hold[1], hold[2], w);
          end
          got = 1;
          if (elem_cnt < FaceSlots) begin
            quad_of_face[elem_cnt] = (nc == 4);
            faces_seen = elem_cnt + 1;
          end
          next_element();
        end else begin
          if (bpos[1:0] == 2'd3) begin
            if (bpos[3:2] < 3) hold[bpos[3:2]] = w;
            accum = 0;
          end
          bpos++;
        end
      end
      PhUv: begin
        if (bpos == 7) begin
          nc = 4;
          if (elem_cnt < faces_seen && elem_cnt < FaceSlots)
            nc = quad_of_face[elem_cnt] ? 4 : 3;
          if (32'(sub_pos) < nc) begin
            r = mk(KIND_UV, elem_cnt, sub_pos[1:0], nc[2:0], hold[0], w, 0, 0);
            got = 1;
          end
          bpos = 0; accum = 0;
          sub_pos++;
          if (sub_pos >= 4) next_element();
        end else begin
          if (bpos == 3) begin
            hold[0] = w;
            accum = 0;
          end
          bpos++;
        end
      end
      PhColor: begin
        if (bpos == 3) begin
          r = mk(KIND_COLOR, elem_cnt, 0, 0, w[23:16], w[15:8], w[7:0], w[31:24]);
          got = 1;
          next_element();
        end else bpos++;
      end
      PhMask, PhGroup: begin
        if (bpos == 1) begin
          r = mk(phase == PhMask ? KIND_MASK : KIND_GROUP, elem_cnt, 0, 0, w[15:0], 0, 0, 0);
          got = 1;
          next_element();
        end else bpos++;
      end
      default: ;
    endcase
    if (last) begin
      if (phase != PhDone) begin
        r = mk(KIND_TRUNC, 0, 0, 0, 0, 0, 0, 0);
        got = 1;
      end
      restart_file();
    end
    if (got) expected_results = {expected_results, r};
  endtask

  task automatic compare_result();
    result_t e, a;
    a = mk(kind_e'(out_i.kind), out_i.elem_index, out_i.corner, out_i.n_corners,
           out_i.val_a, out_i.val_b, out_i.val_c, out_i.val_d);
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result %h", $time, a);
    end else begin
      e = expected_results.pop_front();
      if (a.kind != e.kind || a.elem_index != e.elem_index || a.corner != e.corner ||
          a.n_corners != e.n_corners || a.val_a != e.val_a || a.val_b != e.val_b ||
          a.val_c != e.val_c || a.val_d != e.val_d) begin
        errors++;
        $display("%0t: mismatch expected %h actual %h", $time, e, a);
      end
    end
  endtask

  initial begin
    errors = 0;
    restart_file();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_file();
      expected_results.delete();
    end else begin
      if (out_i.valid && out_i.ready) compare_result();
      if (in_i.valid && in_i.ready) parse_byte(in_i.data_byte, in_i.stream_end);
    end
  end
endmodule

// ===== verif/tb_tagged_mesh_chunk_parser.sv =====
// tb_tagged_mesh_chunk_parser: builds mesh files byte by byte and drives them into
// the parser with random gaps and stalls; depends on tmcp_pkg, the interfaces, the checker
`timescale 1ns / 1ps
module tb_tagged_mesh_chunk_parser;
  import tmcp_pkg::*;

  localparam int StallLimit = 2000;

  logic clk, rst_n;
  int   errors, pending, idle_cycles;
  int   sent_bytes;
  bit   burst;
  logic [7:0] file_bytes [$];

  tmcp_in_if  in_if ();
  tmcp_out_if out_if ();

  tagged_mesh_chunk_parser dut (.clk_i(clk), .rst_ni(rst_n), .in_i(in_if), .out_o(out_if));

  tmcp_result_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_if), .out_i(out_if),
    .errors_o(errors), .pending_o(pending)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_gap();
    return burst ? 0 : $urandom_range(5);
  endfunction

  initial begin
    int n;
    out_if.ready = 0;
    @(posedge rst_n);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_if.ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  task automatic put32(logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes = {file_bytes, v[8*i +: 8]};
  endtask

  task automatic put_random(int n);
    for (int i = 0; i < n; i++) file_bytes = {file_bytes, 8'($urandom)};
  endtask

  task automatic put_header(logic [31:0] name_len);
    put_random(36);
    put32(name_len);
    put_random(8 + ((name_len < 16) ? 0 : name_len - 16));
  endtask

  task automatic put_face_end(int sel);
    case (sel)
      0: put32(TriMark);
      1: put32(32'd0);
      default: put32($urandom);
    endcase
  endtask

  task automatic put_data_chunk(logic [31:0] tag, int count);
    put32(tag);
    put32($urandom);
    put32(count);
    put32(0);
    for (int e = 0; e < count; e++) begin
      case (tag)
        TagVertex: put_random(12);
        TagFace: begin
          put_random(12);
          put_face_end($urandom_range(2));
        end
        TagUv: put_random(32);
        TagColor: put_random(4);
        default: put_random(2);
      endcase
    end
  endtask

  task automatic put_skip_chunk(logic [31:0] tag, int body);
    put32(tag);
    put32(body + 8);
    put_random(body);
  endtask

  task automatic put_random_chunk();
    logic [31:0] t;
    case ($urandom_range(7))
      0: put_data_chunk(TagVertex, $urandom_range(6));
      1: put_data_chunk(TagFace, $urandom_range(6));
      2: put_data_chunk(TagUv, $urandom_range(7));
      3: put_data_chunk(TagColor, $urandom_range(8));
      4: put_data_chunk(TagMask, $urandom_range(8));
      5: put_data_chunk(TagGroup, $urandom_range(8));
      6: put_skip_chunk(32'h0000_1389, $urandom_range(12));
      default: begin
        do t = $urandom;
        while (t == TagEnd || t == TagVertex || t == TagFace || t == TagUv ||
               t == TagColor || t == TagMask || t == TagGroup);
        put_skip_chunk(t, $urandom_range(12));
      end
    endcase
  endtask

  task automatic send_file(int cut);
    int last_idx;
    last_idx = (cut >= 0 && cut < file_bytes.size()) ? cut : file_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      int g;
      g = pick_gap();
      if (g > 0) begin
        in_if.valid <= 0;
        repeat (g) @(posedge clk);
      end
      in_if.valid      <= 1;
      in_if.data_byte  <= file_bytes[i];
      in_if.stream_end <= (i == last_idx);
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
    end
    sent_bytes += last_idx + 1;
    file_bytes.delete();
  endtask

  initial begin
    in_if.valid = 0;
    in_if.data_byte = 0;
    in_if.stream_end = 0;
    rst_n = 0;
    burst = 0;
    idle_cycles = 0;
    sent_bytes = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed file: every chunk kind, all face shapes, uv past the faces, empty chunk
    put_header(32'd3);
    put_skip_chunk(32'h0000_1389, 4);
    put_skip_chunk(32'h1234_5678, 0);
    put_data_chunk(TagVertex, 2);
    put32(TagFace); put32(0); put32(3); put32(0);
    put32(0); put32(0); put32(0); put_face_end(0);
    put32(32'hffff_ffff); put32(32'hffff_ffff); put32(32'hffff_ffff); put_face_end(1);
    put_random(12); put_face_end(2);
    put_data_chunk(TagUv, 5);
    put_data_chunk(TagColor, 0);
    put_data_chunk(TagColor, 2);
    put_data_chunk(TagMask, 2);
    put_data_chunk(TagGroup, 2);
    put32(TagEnd);
    put_random(3);
    send_file(-1);
    put_header(32'd16);
    put_random(20);
    send_file(-1);
    put_header(32'd20);
    send_file(1);

    while (sent_bytes < 900) begin
      burst = ($urandom_range(3) == 0);
      case ($urandom_range(3))
        0: put_header($urandom_range(15));
        default: put_header($urandom_range(16, 40));
      endcase
      for (int c = $urandom_range(1, 6); c > 0; c--) put_random_chunk();
      put32(TagEnd);
      put_random($urandom_range(4));
      send_file(($urandom_range(4) == 0) ? $urandom_range(file_bytes.size() - 1) : -1);
    end
    in_if.valid <= 0;
    burst = 0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== files.f =====
design/tmcp_pkg.sv
design/tmcp_in_if.sv
design/tmcp_out_if.sv
design/tmcp_quad_store.sv
design/tagged_mesh_chunk_parser.sv
verif/tmcp_result_checker.sv
verif/tb_tagged_mesh_chunk_parser.sv
